FILE: design/atrf_pkg.sv
// ----------------------------------------------------------------------------
// atrf_pkg
// Shared types and constants of the transmit-request framer: register
// indexes, configuration struct, queue entry and frame header layout.
// ----------------------------------------------------------------------------
package atrf_pkg;

    localparam logic [7:0]  START_DELIM   = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE    = 8'h10;
    localparam logic [15:0] HEADER_PARAMS = 16'h000E;
    localparam logic [7:0]  SUM_BASE      = 8'hFF;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_IDENT  = 3'd0,
        CFG_DEST_LONG    = 3'd1,
        CFG_DEST_SHORT   = 3'd2,
        CFG_HOP_RADIUS   = 3'd3,
        CFG_SEND_OPTIONS = 3'd4
    } cfg_index_t;

    localparam logic [7:0]  RST_FRAME_IDENT  = 8'h01;
    localparam logic [63:0] RST_DEST_LONG    = 64'h0;
    localparam logic [15:0] RST_DEST_SHORT   = 16'hFFFF;
    localparam logic [7:0]  RST_HOP_RADIUS   = 8'h00;
    localparam logic [7:0]  RST_SEND_OPTIONS = 8'h00;

    // header byte positions, delimiter first
    localparam int HDR_IDX_W = 5;
    localparam logic [HDR_IDX_W-1:0] HDR_DELIM      = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI     = 5'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO     = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE       = 5'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_IDENT      = 5'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_LONG_LAST  = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_SHORT_HI   = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_SHORT_LO   = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_RADIUS     = 5'd15;
    localparam logic [HDR_IDX_W-1:0] HDR_OPTIONS    = 5'd16;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  frame_ident;
        logic [63:0] dest_long_address;
        logic [15:0] dest_short_address;
        logic [7:0]  hop_radius;
        logic [7:0]  send_options;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [15:0] frame_len;
    } q_entry_t;

endpackage

FILE: design/api_transmit_request_framer_unit.sv
// ----------------------------------------------------------------------------
// api_transmit_request_framer_unit
// An accepted item passes through a queue slot and then the back
// sequencer's output register. Throughput: one payload byte per cycle
// inside a frame while out_stall is low and the queue holds work; a frame's
// first item adds the header bytes and its last item the checksum byte.
// Reset: registers return to their defaults, queue empties, the block
// waits for the first byte of a new frame.
// ----------------------------------------------------------------------------
module api_transmit_request_framer_unit #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic [8:0]                     payload_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     frame_byte,
    output logic                           end_of_frame,
    output logic                           end_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [atrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);

    atrf_pkg::cfg_t     cfg_reg;
    atrf_pkg::q_entry_t q_wdata;
    atrf_pkg::q_entry_t q_head;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic               q_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_ident        <= atrf_pkg::RST_FRAME_IDENT;
            cfg_reg.dest_long_address  <= atrf_pkg::RST_DEST_LONG;
            cfg_reg.dest_short_address <= atrf_pkg::RST_DEST_SHORT;
            cfg_reg.hop_radius         <= atrf_pkg::RST_HOP_RADIUS;
            cfg_reg.send_options       <= atrf_pkg::RST_SEND_OPTIONS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                atrf_pkg::CFG_FRAME_IDENT:  cfg_reg.frame_ident        <= cfg_data[7:0];
                atrf_pkg::CFG_DEST_LONG:    cfg_reg.dest_long_address  <= cfg_data;
                atrf_pkg::CFG_DEST_SHORT:   cfg_reg.dest_short_address <= cfg_data[15:0];
                atrf_pkg::CFG_HOP_RADIUS:   cfg_reg.hop_radius         <= cfg_data[7:0];
                atrf_pkg::CFG_SEND_OPTIONS: cfg_reg.send_options       <= cfg_data[7:0];
                default:
                begin
                    // unknown index, ignored
                end
            endcase
        end
    end

    atrf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .payload_length (payload_length),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    atrf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .head    (q_head),
        .q_valid (q_valid),
        .q_full  (q_full)
    );

    atrf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .head         (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .end_of_run   (end_of_run)
    );

    // checksum byte always closes the run of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_run)
        else $error("end_of_frame without end_of_run");

    // back never retires an item the queue does not hold
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    // input stalls only behind a full queue with work at its head
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("input stalled with empty queue");

endmodule

FILE: design/atrf_front.sv
// ----------------------------------------------------------------------------
// atrf_front
// Accepts payload items, tracks frame position and tags each item as
// first and/or last of its frame before queuing it.
// ----------------------------------------------------------------------------
module atrf_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic [8:0]         payload_length,
    input  logic               q_full,
    output logic               q_push,
    output atrf_pkg::q_entry_t q_wdata
);

    logic       inside_frame_reg;
    logic [8:0] bytes_left_reg;
    logic [8:0] len_clip;
    logic [8:0] left_now;
    logic [8:0] left_after;
    logic       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        len_clip = payload_length;
        if (payload_length == 9'd0)
        begin
            len_clip = 9'd1;
        end
        else if (32'(payload_length) > 32'(MAX_PAYLOAD))
        begin
            len_clip = 9'(MAX_PAYLOAD);
        end
    end

    assign left_now   = inside_frame_reg ? bytes_left_reg : len_clip;
    assign left_after = left_now - 9'd1;

    assign q_wdata.data_byte = data_byte;
    assign q_wdata.first     = !inside_frame_reg;
    assign q_wdata.last      = (left_after == 9'd0);
    assign q_wdata.frame_len = {7'd0, len_clip} + atrf_pkg::HEADER_PARAMS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            bytes_left_reg   <= 9'd0;
        end
        else if (accept)
        begin
            inside_frame_reg <= (left_after != 9'd0);
            bytes_left_reg   <= left_after;
        end
    end

endmodule

FILE: design/atrf_queue.sv
// ----------------------------------------------------------------------------
// atrf_queue
// Two-entry queue between the front and the back, so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module atrf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  atrf_pkg::q_entry_t wdata,
    input  logic               pop,
    output atrf_pkg::q_entry_t head,
    output logic               q_valid,
    output logic               q_full
);

    localparam int PTR_W = $clog2(atrf_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(atrf_pkg::Q_DEPTH + 1);

    atrf_pkg::q_entry_t slot_reg [atrf_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign head    = slot_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(atrf_pkg::Q_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % atrf_pkg::Q_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % atrf_pkg::Q_DEPTH);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/atrf_back.sv
// ----------------------------------------------------------------------------
// atrf_back
// Serializes queued items: header burst on a frame's first item, the
// payload byte, and the checksum after a frame's last item.
// ----------------------------------------------------------------------------
module atrf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  atrf_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  atrf_pkg::q_entry_t head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         frame_byte,
    output logic               end_of_frame,
    output logic               end_of_run
);

    typedef enum logic [1:0] {
        PH_START,
        PH_HDR,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [atrf_pkg::HDR_IDX_W-1:0]      idx_reg;
    logic [atrf_pkg::HDR_IDX_W-1:0]      idx_next;
    logic [7:0]                          sum_reg;
    logic [7:0]                          sum_next;
    logic                                out_valid_reg;
    logic [7:0]                          frame_byte_reg;
    logic [7:0]                          frame_byte_next;
    logic                                end_of_frame_reg;
    logic                                end_of_frame_next;
    logic                                end_of_run_reg;
    logic                                end_of_run_next;
    logic                                pop_step;
    logic                                load;
    logic [7:0]                          hdr_byte;
    logic [2:0]                          long_sel;

    assign load = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = load && pop_step;

    assign out_valid    = out_valid_reg;
    assign frame_byte   = frame_byte_reg;
    assign end_of_frame = end_of_frame_reg;
    assign end_of_run   = end_of_run_reg;

    // address byte, most significant first
    assign long_sel = 3'(atrf_pkg::HDR_LONG_LAST - idx_reg);

    always_comb
    begin
        unique case (idx_reg)
            atrf_pkg::HDR_DELIM:    hdr_byte = atrf_pkg::START_DELIM;
            atrf_pkg::HDR_LEN_HI:   hdr_byte = head.frame_len[15:8];
            atrf_pkg::HDR_LEN_LO:   hdr_byte = head.frame_len[7:0];
            atrf_pkg::HDR_TYPE:     hdr_byte = atrf_pkg::FRAME_TYPE;
            atrf_pkg::HDR_IDENT:    hdr_byte = cfg.frame_ident;
            atrf_pkg::HDR_SHORT_HI: hdr_byte = cfg.dest_short_address[15:8];
            atrf_pkg::HDR_SHORT_LO: hdr_byte = cfg.dest_short_address[7:0];
            atrf_pkg::HDR_RADIUS:   hdr_byte = cfg.hop_radius;
            atrf_pkg::HDR_OPTIONS:  hdr_byte = cfg.send_options;
            default:                hdr_byte = cfg.dest_long_address[long_sel*8 +: 8];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        idx_next          = idx_reg;
        sum_next          = sum_reg;
        frame_byte_next   = head.data_byte;
        end_of_frame_next = 1'b0;
        end_of_run_next   = 1'b0;
        pop_step          = 1'b0;
        unique case (phase_reg)
            PH_START, PH_DATA:
            begin
                if (phase_reg == PH_START && head.first)
                begin
                    frame_byte_next = atrf_pkg::START_DELIM;
                    sum_next        = 8'd0;
                    idx_next        = atrf_pkg::HDR_LEN_HI;
                    phase_next      = PH_HDR;
                end
                else
                begin
                    sum_next = sum_reg + head.data_byte;
                    if (head.last)
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        pop_step        = 1'b1;
                        end_of_run_next = 1'b1;
                        phase_next      = PH_START;
                    end
                end
            end
            PH_HDR:
            begin
                frame_byte_next = hdr_byte;
                // checksum covers the type byte onward
                if (idx_reg >= atrf_pkg::HDR_TYPE)
                begin
                    sum_next = sum_reg + hdr_byte;
                end
                if (idx_reg == atrf_pkg::HDR_OPTIONS)
                begin
                    phase_next = PH_DATA;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            PH_SUM:
            begin
                frame_byte_next   = atrf_pkg::SUM_BASE - sum_reg;
                end_of_frame_next = 1'b1;
                end_of_run_next   = 1'b1;
                pop_step          = 1'b1;
                sum_next          = 8'd0;
                phase_next        = PH_START;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            idx_reg          <= atrf_pkg::HDR_DELIM;
            sum_reg          <= 8'd0;
            out_valid_reg    <= 1'b0;
            frame_byte_reg   <= 8'd0;
            end_of_frame_reg <= 1'b0;
            end_of_run_reg   <= 1'b0;
        end
        else if (load)
        begin
            phase_reg        <= phase_next;
            idx_reg          <= idx_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= 1'b1;
            frame_byte_reg   <= frame_byte_next;
            end_of_frame_reg <= end_of_frame_next;
            end_of_run_reg   <= end_of_run_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
